// File: hdl/msch_pkg.sv
`default_nettype none
package msch_pkg;

  localparam int NUM_SLOTS = 64;
  localparam int SIDX_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int PTR_W     = $clog2(NUM_SLOTS + 1);

  // find-first search: slots are split into groups of GRP
  localparam int GRP     = 8;
  localparam int GOFF_W  = $clog2(GRP);
  localparam int NGRP    = (NUM_SLOTS + GRP - 1) / GRP;

  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  localparam int SLOT_W  = 6;
  localparam int SLICE_W = 16;

  // input action codes
  localparam logic [2:0] ACT_NEW   = 3'd0;
  localparam logic [2:0] ACT_WAKE  = 3'd1;
  localparam logic [2:0] ACT_SLEEP = 3'd2;
  localparam logic [2:0] ACT_DISP  = 3'd3;
  localparam logic [2:0] ACT_RET   = 3'd4;

  // internal operation codes after classification
  localparam logic [2:0] OP_NOP   = 3'd0;
  localparam logic [2:0] OP_NEW   = 3'd1;
  localparam logic [2:0] OP_WAKE  = 3'd2;
  localparam logic [2:0] OP_SLEEP = 3'd3;
  localparam logic [2:0] OP_DISP  = 3'd4;
  localparam logic [2:0] OP_RET   = 3'd5;

  localparam logic [1:0] LVL_TOP = 2'd0;
  localparam logic [1:0] LVL_MID = 2'd1;
  localparam logic [1:0] LVL_LOW = 2'd2;

  localparam logic [1:0] CFG_SLICE_HIGH = 2'd0;
  localparam logic [1:0] CFG_SLICE_MID  = 2'd1;
  localparam logic [1:0] CFG_SLICE_LOW  = 2'd2;

  localparam logic [SLICE_W-1:0] SLICE_HIGH_RST = 16'd200;
  localparam logic [SLICE_W-1:0] SLICE_MID_RST  = 16'd300;
  localparam logic [SLICE_W-1:0] SLICE_LOW_RST  = 16'd350;

  typedef struct packed {
    logic [2:0]        action;
    logic [SLOT_W-1:0] slot;
    logic              still_ready;
    logic              slice_used_up;
  } in_item_t;

  typedef struct packed {
    logic               granted;
    logic [SLOT_W-1:0]  grant_slot;
    logic [1:0]         grant_level;
    logic [SLICE_W-1:0] slice_length;
  } out_item_t;

  typedef struct packed {
    logic [2:0]        op;
    logic [SIDX_W-1:0] idx;
    logic              still;
    logic              used;
  } q_entry_t;

  typedef struct packed {
    logic [SLICE_W-1:0] high;
    logic [SLICE_W-1:0] mid;
    logic [SLICE_W-1:0] low;
  } slice_cfg_t;

  typedef struct packed {
    logic              done;
    logic              found;
    logic [SIDX_W-1:0] idx;
  } srch_rsp_t;

  function automatic logic [SIDX_W-1:0] slot_to_idx(input logic [SLOT_W-1:0] s);
    logic [31:0] w;
    w = 32'(s);
    return w[SIDX_W-1:0];
  endfunction

  function automatic logic [SLOT_W-1:0] idx_to_slot(input logic [SIDX_W-1:0] i);
    logic [31:0] w;
    w = 32'(i);
    return w[SLOT_W-1:0];
  endfunction

endpackage
`default_nettype wire

// File: hdl/msch_front.sv
`default_nettype none
module msch_front
  import msch_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  output logic          busy,
  input  wire in_item_t in_item,
  output logic          q_valid,
  output q_entry_t      q_entry,
  input  wire logic     q_pop
);

  q_entry_t            q_mem_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   cnt_r, cnt_nxt;
  logic                push;
  logic                do_pop;
  logic                slot_ok;
  q_entry_t            cls;

  assign busy    = (cnt_r == QCNT_W'(QDEPTH));
  assign push    = start && !busy;
  assign q_valid = (cnt_r != '0);
  assign q_entry = q_mem_r[rd_ptr_r];
  assign do_pop  = q_pop && q_valid;

  // classify the transaction; out-of-range slots turn slot events into no-ops
  always_comb begin
    slot_ok   = (32'(in_item.slot) < NUM_SLOTS);
    cls.idx   = slot_to_idx(in_item.slot);
    cls.still = in_item.still_ready;
    cls.used  = in_item.slice_used_up;
    unique case (in_item.action)
      ACT_NEW:   cls.op = slot_ok ? OP_NEW   : OP_NOP;
      ACT_WAKE:  cls.op = slot_ok ? OP_WAKE  : OP_NOP;
      ACT_SLEEP: cls.op = slot_ok ? OP_SLEEP : OP_NOP;
      ACT_DISP:  cls.op = OP_DISP;
      ACT_RET:   cls.op = slot_ok ? OP_RET   : OP_NOP;
      default:   cls.op = OP_NOP;
    endcase
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !do_pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (!push && do_pop) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= cls;
    end
  end

endmodule
`default_nettype wire

// File: hdl/msch_search.sv
`default_nettype none
module msch_search
  import msch_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 go,
  input  wire logic [NUM_SLOTS-1:0] cand,
  output srch_rsp_t                 rsp
);

  logic [NGRP*GRP-1:0] pad;
  logic [NGRP-1:0]     any_nxt, any_r;
  logic [GOFF_W-1:0]   off_nxt [NGRP];
  logic [GOFF_W-1:0]   off_r   [NGRP];
  logic                s1_r;
  srch_rsp_t           rsp_nxt, rsp_r;

  assign pad = (NGRP*GRP)'(cand);

  // stage one: any bit and first offset in each group
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      any_nxt[g] = |pad[g*GRP +: GRP];
      off_nxt[g] = '0;
      for (int b = GRP - 1; b >= 0; b--) begin
        if (pad[g*GRP + b]) off_nxt[g] = GOFF_W'(b);
      end
    end
  end

  // stage two: first group that has a hit
  always_comb begin
    rsp_nxt.done  = s1_r;
    rsp_nxt.found = |any_r;
    rsp_nxt.idx   = '0;
    for (int g = NGRP - 1; g >= 0; g--) begin
      if (any_r[g]) rsp_nxt.idx = SIDX_W'(g*GRP + int'(off_r[g]));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r  <= 1'b0;
      rsp_r <= '0;
    end else begin
      s1_r  <= go;
      rsp_r <= rsp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    any_r <= any_nxt;
    off_r <= off_nxt;
  end

  assign rsp = rsp_r;

endmodule
`default_nettype wire

// File: hdl/msch_back.sv
`default_nettype none
module msch_back
  import msch_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       q_valid,
  input  wire q_entry_t   q_entry,
  output logic            q_pop,
  input  wire slice_cfg_t slices,
  output logic            out_valid,
  output out_item_t       out_item
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_EXEC = 3'd1;
  localparam logic [2:0] ST_LVL  = 3'd2;
  localparam logic [2:0] ST_DSET = 3'd3;
  localparam logic [2:0] ST_SRCH = 3'd4;
  localparam logic [2:0] ST_WAIT = 3'd5;

  logic [2:0]           st_r, st_nxt;
  q_entry_t             cur_r, cur_nxt;
  // rdy_r[l][i]: slot i is ready and sits at level l
  logic [NUM_SLOTS-1:0] rdy_r [3];
  logic [NUM_SLOTS-1:0] rdy_nxt [3];
  logic [NUM_SLOTS-1:0] vld_r, vld_nxt;
  logic [1:0]           pl_r, pl_nxt;
  logic [PTR_W-1:0]     ptr_r, ptr_nxt;
  logic                 act_r, act_nxt;
  logic                 retry_r, retry_nxt;
  logic                 ov_r, ov_nxt;
  out_item_t            oi_r, oi_nxt;

  logic [1:0]           lvl_mem [NUM_SLOTS];
  logic [1:0]           lvl_rd_r;
  logic                 mem_we, mem_re;
  logic [1:0]           mem_wdata;

  logic [1:0]           best;
  logic [1:0]           lvl_cur;
  logic [1:0]           lvl_new;
  logic [NUM_SLOTS-1:0] ge;
  logic [NUM_SLOTS-1:0] cand;
  logic                 srch_go;
  srch_rsp_t            rsp;
  logic [SLICE_W-1:0]   pl_slice;

  msch_search u_search (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (srch_go),
    .cand  (cand),
    .rsp   (rsp)
  );

  always_comb begin
    priority if (|rdy_r[LVL_TOP]) best = LVL_TOP;
    else if (|rdy_r[LVL_MID])     best = LVL_MID;
    else                          best = LVL_LOW;
  end

  always_comb begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      ge[i] = (PTR_W'(i) >= ptr_r);
    end
    unique case (pl_r)
      LVL_TOP: cand = rdy_r[LVL_TOP] & ge;
      LVL_MID: cand = rdy_r[LVL_MID] & ge;
      default: cand = rdy_r[LVL_LOW] & ge;
    endcase
    unique case (pl_r)
      LVL_TOP: pl_slice = slices.high;
      LVL_MID: pl_slice = slices.mid;
      default: pl_slice = slices.low;
    endcase
  end

  assign lvl_cur = vld_r[cur_r.idx] ? lvl_rd_r : LVL_TOP;
  assign lvl_new = (cur_r.used && (lvl_cur == LVL_TOP || lvl_cur == LVL_MID))
                   ? lvl_cur + 2'd1 : lvl_cur;

  always_comb begin
    st_nxt    = st_r;
    cur_nxt   = cur_r;
    rdy_nxt   = rdy_r;
    vld_nxt   = vld_r;
    pl_nxt    = pl_r;
    ptr_nxt   = ptr_r;
    act_nxt   = act_r;
    retry_nxt = retry_r;
    ov_nxt    = 1'b0;
    oi_nxt    = '0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_wdata = LVL_TOP;
    q_pop     = 1'b0;
    srch_go   = 1'b0;

    unique case (st_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop   = 1'b1;
          cur_nxt = q_entry;
          st_nxt  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        unique case (cur_r.op)
          OP_NEW: begin
            for (int l = 0; l < 3; l++) rdy_nxt[l][cur_r.idx] = 1'b0;
            rdy_nxt[LVL_TOP][cur_r.idx] = 1'b1;
            mem_we               = 1'b1;
            mem_wdata            = LVL_TOP;
            vld_nxt[cur_r.idx]   = 1'b1;
            ov_nxt               = 1'b1;
            st_nxt               = ST_IDLE;
          end
          OP_WAKE, OP_RET: begin
            mem_re = 1'b1;
            st_nxt = ST_LVL;
          end
          OP_SLEEP: begin
            for (int l = 0; l < 3; l++) rdy_nxt[l][cur_r.idx] = 1'b0;
            ov_nxt = 1'b1;
            st_nxt = ST_IDLE;
          end
          OP_DISP: begin
            st_nxt = ST_DSET;
          end
          default: begin
            ov_nxt = 1'b1;
            st_nxt = ST_IDLE;
          end
        endcase
      end
      ST_LVL: begin
        if (cur_r.op == OP_WAKE) begin
          rdy_nxt[lvl_cur][cur_r.idx] = 1'b1;
        end else begin
          for (int l = 0; l < 3; l++) rdy_nxt[l][cur_r.idx] = 1'b0;
          if (cur_r.still) begin
            rdy_nxt[lvl_new][cur_r.idx] = 1'b1;
            mem_we             = 1'b1;
            mem_wdata          = lvl_new;
            vld_nxt[cur_r.idx] = 1'b1;
          end
        end
        ov_nxt = 1'b1;
        st_nxt = ST_IDLE;
      end
      ST_DSET: begin
        if (!act_r) begin
          pl_nxt  = best;
          ptr_nxt = '0;
          act_nxt = 1'b1;
        end
        retry_nxt = 1'b0;
        st_nxt    = ST_SRCH;
      end
      ST_SRCH: begin
        srch_go = 1'b1;
        st_nxt  = ST_WAIT;
      end
      ST_WAIT: begin
        if (rsp.done) begin
          if (rsp.found) begin
            rdy_nxt[pl_r][rsp.idx] = 1'b0;
            ptr_nxt             = PTR_W'(rsp.idx) + PTR_W'(1);
            ov_nxt              = 1'b1;
            oi_nxt.granted      = 1'b1;
            oi_nxt.grant_slot   = idx_to_slot(rsp.idx);
            oi_nxt.grant_level  = pl_r;
            oi_nxt.slice_length = pl_slice;
            st_nxt              = ST_IDLE;
          end else if (!retry_r) begin
            // end of table: recompute the pass level and rescan once
            pl_nxt    = best;
            ptr_nxt   = '0;
            retry_nxt = 1'b1;
            st_nxt    = ST_SRCH;
          end else begin
            act_nxt = 1'b0;
            ptr_nxt = '0;
            ov_nxt  = 1'b1;
            st_nxt  = ST_IDLE;
          end
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= ST_IDLE;
      rdy_r   <= '{default: '0};
      vld_r   <= '0;
      pl_r    <= LVL_LOW;
      ptr_r   <= '0;
      act_r   <= 1'b0;
      retry_r <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      rdy_r   <= rdy_nxt;
      vld_r   <= vld_nxt;
      pl_r    <= pl_nxt;
      ptr_r   <= ptr_nxt;
      act_r   <= act_nxt;
      retry_r <= retry_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    oi_r  <= oi_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      lvl_mem[cur_r.idx] <= mem_wdata;
    end
    if (mem_re) begin
      lvl_rd_r <= lvl_mem[cur_r.idx];
    end
  end

  assign out_valid = ov_r;
  assign out_item  = oi_r;

endmodule
`default_nettype wire

// File: hdl/multilevel_feedback_scheduler.sv
// Three-level feedback scheduler over a table of task slots.
// Input channel: present in_item with start high; the transaction is taken
// at a rising edge where busy is low. A two-entry queue sits between the
// front end that takes and classifies transactions and the back end that
// executes them, so busy rises only when that queue is full.
// Result channel: exactly one result per transaction, in order, shown on
// out_item for one cycle with out_valid high. The receiver cannot stall.
// Slot events (new, wake, not ready, return) and ignored codes are executed
// directly by the back end; a dispatch scans for a ready slot and, when the
// scan reaches the end of the table, recomputes the level and restarts once.
// The back end executes one transaction at a time and takes no new one from
// the queue before the last one has its result. Dispatch time is set by the
// two-stage registered find-first search over the ready masks.
// Configuration: cfg_index selects slice_high (0), slice_mid (1) or
// slice_low (2); cfg_ready is always high. Write only while idle.
// Reset (rst_n low, synchronous): queue empty, nothing ready, every slot at
// the top level, no pass running, slices back to 200, 300 and 350.
`default_nettype none
module multilevel_feedback_scheduler
  import msch_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire in_item_t           in_item,
  output logic                    out_valid,
  output out_item_t               out_item,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [SLICE_W-1:0] cfg_data
);

  slice_cfg_t slices_r, slices_nxt;
  logic       q_valid;
  q_entry_t   q_entry;
  logic       q_pop;

  assign cfg_ready = 1'b1;

  always_comb begin
    slices_nxt = slices_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_SLICE_HIGH: slices_nxt.high = cfg_data;
        CFG_SLICE_MID:  slices_nxt.mid  = cfg_data;
        CFG_SLICE_LOW:  slices_nxt.low  = cfg_data;
        default:        slices_nxt      = slices_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slices_r.high <= SLICE_HIGH_RST;
      slices_r.mid  <= SLICE_MID_RST;
      slices_r.low  <= SLICE_LOW_RST;
    end else begin
      slices_r <= slices_nxt;
    end
  end

  msch_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .in_item (in_item),
    .q_valid (q_valid),
    .q_entry (q_entry),
    .q_pop   (q_pop)
  );

  msch_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_entry   (q_entry),
    .q_pop     (q_pop),
    .slices    (slices_r),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule
`default_nettype wire

// File: hdl/msch_checker.sv
`default_nettype none
module msch_checker
  import msch_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      start,
  input wire logic      busy,
  input wire logic      out_valid,
  input wire out_item_t out_item
);

  // no result leaves the block right after a reset cycle
  a_no_result_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result strobe right after reset");

  // reset empties the queue
  a_not_busy_after_reset: assert property (@(posedge clk)
    !rst_n |=> !busy)
    else $error("busy right after reset");

  // a result without a grant carries all-zero fields
  a_zero_when_not_granted: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_item.granted) |->
      (out_item.grant_slot == '0 && out_item.grant_level == '0 &&
       out_item.slice_length == '0))
    else $error("non-grant result with nonzero fields");

  // a granted level is one of the three levels
  a_grant_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.granted) |->
      (out_item.grant_level == LVL_TOP || out_item.grant_level == LVL_MID ||
       out_item.grant_level == LVL_LOW))
    else $error("grant at a level that does not exist");

  // a result never appears in the same cycle a transaction is first taken
  // from an empty, idle block after reset
  a_no_result_same_cycle_as_reset_accept: assert property (@(posedge clk)
    disable iff (!rst_n)
    ($past(!rst_n) && start && !busy) |-> !out_valid)
    else $error("result without a preceding transaction");

endmodule

bind multilevel_feedback_scheduler msch_checker u_msch_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_item  (out_item)
);
`default_nettype wire

// File: tb/multilevel_feedback_scheduler_checker.sv
`timescale 1ns / 1ps
module multilevel_feedback_scheduler_checker
  import msch_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  in_item_t           in_item,
  input  logic               out_valid,
  input  out_item_t          out_item,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [SLICE_W-1:0] cfg_data,
  output int                 errors,
  output int                 pending,
  output int                 grants,
  output int                 empty_dispatches
);

  logic       ready_map [NUM_SLOTS];
  logic [1:0] level_map [NUM_SLOTS];
  int         scan_ptr;
  logic [1:0] pass_lvl;
  logic       pass_on;
  slice_cfg_t slices;
  out_item_t  grant_reports [$];

  function automatic logic [SLICE_W-1:0] slice_for(input logic [1:0] lvl);
    case (lvl)
      LVL_TOP: return slices.high;
      LVL_MID: return slices.mid;
      default: return slices.low;
    endcase
  endfunction

  // best level among ready slots, lowest level when nothing is ready
  function automatic logic [1:0] best_level();
    logic [1:0] best;
    best = LVL_LOW;
    for (int i = 0; i < NUM_SLOTS; i++)
      if (ready_map[i] && level_map[i] < best) best = level_map[i];
    return best;
  endfunction

  function automatic int find_ready(input int from);
    for (int i = from; i < NUM_SLOTS; i++)
      if (ready_map[i] && level_map[i] == pass_lvl) return i;
    return -1;
  endfunction

  task automatic schedule_event(input in_item_t ev, output out_item_t res);
    int hit;
    bit slot_ok;
    res = '0;
    slot_ok = int'(ev.slot) < NUM_SLOTS;
    case (ev.action)
      ACT_NEW: begin
        if (slot_ok) begin
          ready_map[ev.slot] = 1'b1;
          level_map[ev.slot] = LVL_TOP;
        end
      end
      ACT_WAKE: begin
        if (slot_ok) ready_map[ev.slot] = 1'b1;
      end
      ACT_SLEEP: begin
        if (slot_ok) ready_map[ev.slot] = 1'b0;
      end
      ACT_DISP: begin
        if (!pass_on) begin
          pass_lvl = best_level();
          scan_ptr = 0;
          pass_on  = 1'b1;
        end
        hit = find_ready(scan_ptr);
        // end of table: recompute the level and restart once
        if (hit < 0) begin
          pass_lvl = best_level();
          scan_ptr = 0;
          hit      = find_ready(0);
        end
        if (hit < 0) begin
          pass_on  = 1'b0;
          scan_ptr = 0;
          empty_dispatches++;
        end else begin
          ready_map[hit]   = 1'b0;
          scan_ptr         = hit + 1;
          res.granted      = 1'b1;
          res.grant_slot   = SLOT_W'(hit);
          res.grant_level  = level_map[hit];
          res.slice_length = slice_for(level_map[hit]);
          grants++;
        end
      end
      ACT_RET: begin
        if (slot_ok) begin
          ready_map[ev.slot] = ev.still_ready;
          if (ev.still_ready && ev.slice_used_up && level_map[ev.slot] < LVL_LOW)
            level_map[ev.slot] = level_map[ev.slot] + 2'd1;
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    out_item_t predicted;
    out_item_t want;
    if (!rst_n) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        ready_map[i] = 1'b0;
        level_map[i] = LVL_TOP;
      end
      scan_ptr         = 0;
      pass_lvl         = LVL_LOW;
      pass_on          = 1'b0;
      slices.high      = SLICE_HIGH_RST;
      slices.mid       = SLICE_MID_RST;
      slices.low       = SLICE_LOW_RST;
      errors           = 0;
      grants           = 0;
      empty_dispatches = 0;
      grant_reports.delete();
      pending <= 0;
    end else begin
      // results leave before this edge's transaction, so check first
      if (out_valid) begin
        if (grant_reports.size() == 0) begin
          if (errors < 10)
            $display("%0t: unexpected result granted=%0d slot=%0d level=%0d slice=%0d",
                     $realtime, out_item.granted, out_item.grant_slot,
                     out_item.grant_level, out_item.slice_length);
          errors++;
        end else begin
          want = grant_reports.pop_front();
          if (out_item.granted !== want.granted || out_item.grant_slot !== want.grant_slot ||
              out_item.grant_level !== want.grant_level ||
              out_item.slice_length !== want.slice_length) begin
            if (errors < 10)
              $display({"%0t: result mismatch exp g=%0d s=%0d l=%0d t=%0d",
                        " got g=%0d s=%0d l=%0d t=%0d"},
                       $realtime, want.granted, want.grant_slot, want.grant_level,
                       want.slice_length, out_item.granted, out_item.grant_slot,
                       out_item.grant_level, out_item.slice_length);
            errors++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SLICE_HIGH: slices.high = cfg_data;
          CFG_SLICE_MID:  slices.mid  = cfg_data;
          CFG_SLICE_LOW:  slices.low  = cfg_data;
          default: ;
        endcase
      end
      if (start && !busy) begin
        schedule_event(in_item, predicted);
        grant_reports.push_back(predicted);
      end
      pending <= grant_reports.size();
    end
  end

endmodule

// File: tb/multilevel_feedback_scheduler_tb.sv
`timescale 1ns / 1ps
module multilevel_feedback_scheduler_tb;
  import msch_pkg::*;

  localparam int         STALL_LIMIT = 2000;
  localparam int         NUM_PHASES  = 5;
  localparam int         PHASE_ITEMS = 200;
  localparam int         HOT_SPAN [NUM_PHASES] = '{7, 15, 63, 7, 31};
  localparam logic [2:0] ACT_BAD_LO  = 3'd5;
  localparam logic [2:0] ACT_BAD_MID = 3'd6;
  localparam logic [2:0] ACT_BAD_HI  = 3'd7;
  localparam logic [1:0] CFG_UNUSED  = 2'd3;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               start     = 1'b0;
  logic               busy;
  in_item_t           in_item   = '0;
  logic               out_valid;
  out_item_t          out_item;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = CFG_SLICE_HIGH;
  logic [SLICE_W-1:0] cfg_data  = '0;

  int errors, pending, grants, empty_dispatches;
  int events_sent  = 0;
  int cfg_writes   = 0;
  int quiet_cycles = 0;

  always #5 clk = ~clk;

  multilevel_feedback_scheduler u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  multilevel_feedback_scheduler_checker u_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_item          (in_item),
    .out_valid        (out_valid),
    .out_item         (out_item),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .errors           (errors),
    .pending          (pending),
    .grants           (grants),
    .empty_dispatches (empty_dispatches)
  );

  // end the run if no transaction moves on any channel for too long
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout after %0d quiet cycles, %0d results outstanding", quiet_cycles, pending);
      $display("multilevel_feedback_scheduler verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic in_item_t make_event(input logic [2:0] act, input int slot,
                                          input bit still, input bit used);
    in_item_t ev;
    ev.action        = act;
    ev.slot          = SLOT_W'(slot);
    ev.still_ready   = still;
    ev.slice_used_up = used;
    return ev;
  endfunction

  // mostly scheduler traffic on the hot slots 0 to span, some noise
  function automatic in_item_t pick_event(input int span);
    in_item_t ev;
    int r;
    r = $urandom_range(0, 99);
    if (r < 14)      ev.action = ACT_NEW;
    else if (r < 24) ev.action = ACT_WAKE;
    else if (r < 32) ev.action = ACT_SLEEP;
    else if (r < 64) ev.action = ACT_DISP;
    else if (r < 95) ev.action = ACT_RET;
    else             ev.action = 3'($urandom_range(int'(ACT_BAD_LO), int'(ACT_BAD_HI)));
    if ($urandom_range(0, 3) != 0) ev.slot = SLOT_W'($urandom_range(0, span));
    else                           ev.slot = SLOT_W'($urandom_range(0, NUM_SLOTS - 1));
    ev.still_ready   = ($urandom_range(0, 3) != 0);
    ev.slice_used_up = 1'($urandom_range(0, 1));
    return ev;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // hold start until the transaction is taken
  task automatic send_event(input in_item_t ev);
    start   <= 1'b1;
    in_item <= ev;
    do @(posedge clk); while (busy);
    events_sent++;
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (10) @(posedge clk);
  endtask

  task automatic program_slices(input logic [SLICE_W-1:0] hi, input logic [SLICE_W-1:0] mid,
                                input logic [SLICE_W-1:0] lo, input bit poke_unused);
    logic [1:0]         idx  [4];
    logic [SLICE_W-1:0] vals [4];
    int                 n;
    idx  = '{CFG_SLICE_HIGH, CFG_SLICE_MID, CFG_SLICE_LOW, CFG_UNUSED};
    vals = '{hi, mid, lo, SLICE_W'($urandom)};
    n    = poke_unused ? 4 : 3;
    for (int i = 0; i < n; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= vals[i];
      do @(posedge clk); while (!cfg_ready);
      cfg_writes++;
    end
    cfg_valid <= 1'b0;
  endtask

  initial begin
    in_item_t script [$];
    int       gap;
    bit       burst;
    int       directed;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    script.push_back(make_event(ACT_DISP, 17, 1'b1, 1'b1));  // nothing ready
    script.push_back(make_event(ACT_NEW, 0, 1'b0, 1'b0));
    script.push_back(make_event(ACT_NEW, 63, 1'b1, 1'b1));
    script.push_back(make_event(ACT_NEW, 5, 1'b0, 1'b0));
    script.push_back(make_event(ACT_DISP, 0, 1'b0, 1'b0));
    script.push_back(make_event(ACT_NEW, 2, 1'b0, 1'b0));    // ahead of the scan
    script.push_back(make_event(ACT_DISP, 63, 1'b1, 1'b1));
    script.push_back(make_event(ACT_DISP, 0, 1'b0, 1'b0));
    script.push_back(make_event(ACT_DISP, 0, 1'b0, 1'b0));   // grants slot 63
    script.push_back(make_event(ACT_DISP, 0, 1'b0, 1'b0));   // table empty
    script.push_back(make_event(ACT_RET, 5, 1'b1, 1'b1));
    script.push_back(make_event(ACT_RET, 5, 1'b1, 1'b1));
    script.push_back(make_event(ACT_RET, 5, 1'b1, 1'b1));    // saturate at lowest
    script.push_back(make_event(ACT_RET, 63, 1'b1, 1'b0));
    script.push_back(make_event(ACT_RET, 0, 1'b0, 1'b1));    // not runnable, no demotion
    script.push_back(make_event(ACT_WAKE, 0, 1'b0, 1'b0));
    script.push_back(make_event(ACT_SLEEP, 63, 1'b1, 1'b1));
    script.push_back(make_event(ACT_DISP, 0, 1'b0, 1'b0));
    script.push_back(make_event(ACT_DISP, 0, 1'b0, 1'b0));
    script.push_back(make_event(ACT_NEW, 5, 1'b1, 1'b0));
    script.push_back(make_event(ACT_BAD_LO, 63, 1'b1, 1'b1));
    script.push_back(make_event(ACT_BAD_HI, 42, 1'b0, 1'b1));
    script.push_back(make_event(ACT_BAD_MID, 21, 1'b1, 1'b0));
    script.push_back(make_event(ACT_DISP, 0, 1'b0, 1'b0));
    script.push_back(make_event(ACT_DISP, 0, 1'b0, 1'b0));
    directed = script.size();
    foreach (script[i]) send_event(script[i]);
    drain();

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: program_slices(16'hFFFF, 16'd1, 16'd0, 1'b1);
        1: program_slices(16'd0, 16'hFFFF, 16'd1, 1'b0);
        3: program_slices(16'd1, 16'd0, 16'hFFFF, 1'b0);
        default: program_slices(SLICE_W'($urandom), SLICE_W'($urandom),
                                SLICE_W'($urandom), 1'b1);
      endcase
      burst = 1'b0;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (k % 50 == 0) burst = ($urandom_range(0, 2) == 0);
        gap = burst ? 0 : pick_gap();
        if (gap > 0) begin
          start <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        send_event(pick_event(HOT_SPAN[p]));
      end
      drain();
    end

    $display("%0d events (%0d directed) over %0d slice settings, %0d register writes",
             events_sent, directed, NUM_PHASES + 1, cfg_writes);
    $display("%0d dispatches granted, %0d found nothing, %0d mismatches",
             grants, empty_dispatches, errors);
    if (errors == 0 && pending == 0) begin
      $display("multilevel_feedback_scheduler verification clean");
    end else begin
      $display("multilevel_feedback_scheduler verification failed");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/msch_pkg.sv
hdl/msch_front.sv
hdl/msch_search.sv
hdl/msch_back.sv
hdl/multilevel_feedback_scheduler.sv
hdl/msch_checker.sv
tb/multilevel_feedback_scheduler_checker.sv
tb/multilevel_feedback_scheduler_tb.sv
